[hdl/fsad_pkg.sv]
// shared types, register indexes and reciprocal table for the frame decimator
`timescale 1ns / 1ps

package fsad_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_PIXELS  = 2'd0;
  localparam logic [1:0] CFG_COMBINE_COUNT = 2'd1;
  localparam logic [1:0] CFG_SKIP_COUNT    = 2'd2;

  localparam int CFG_WIDTH   = 17;
  localparam int COUNT_WIDTH = 5;
  localparam int PIX_WIDTH   = 16;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_WIDTH = 20;
  localparam int PROD_WIDTH  = PIX_WIDTH + RECIP_WIDTH;

  localparam logic [PIX_WIDTH-1:0] PASS_MASK = 16'h3fff;

  // what the accumulate stage does with a kept pixel
  typedef enum logic [1:0] {
    ACC_FIRST,   // first frame of a group: store pixel/4
    ACC_SUM,     // middle frame: add pixel/4 into the store
    ACC_AVG,     // last frame: add and emit the average
    ACC_PASS     // group of one: emit the masked pixel
  } acc_op_t;

  // kept pixel going into the accumulate stage
  typedef struct packed {
    logic                   valid;
    acc_op_t                op;
    logic [PIX_WIDTH-1:0]   pixel;
    logic                   last;
    logic [COUNT_WIDTH-1:0] comb;
  } acc_req_t;

  // emitting pixel going into the divide stage
  typedef struct packed {
    logic                   valid;
    logic                   avg;
    logic [PIX_WIDTH-1:0]   value;
    logic                   last;
    logic [COUNT_WIDTH-1:0] comb;
  } div_req_t;

  // finished result beat
  typedef struct packed {
    logic                 valid;
    logic [PIX_WIDTH-1:0] value;
    logic                 last;
  } res_t;

  // ceil(2^20 / d), exact floor division of any 16-bit value for d in 2..16
  function automatic logic [RECIP_WIDTH-1:0] recip(input logic [COUNT_WIDTH-1:0] d);
    logic [RECIP_WIDTH-1:0] m;
    unique case (d)
      5'd2:    m = 20'd524288;
      5'd3:    m = 20'd349526;
      5'd4:    m = 20'd262144;
      5'd5:    m = 20'd209716;
      5'd6:    m = 20'd174763;
      5'd7:    m = 20'd149797;
      5'd8:    m = 20'd131072;
      5'd9:    m = 20'd116509;
      5'd10:   m = 20'd104858;
      5'd11:   m = 20'd95326;
      5'd12:   m = 20'd87382;
      5'd13:   m = 20'd80660;
      5'd14:   m = 20'd74899;
      5'd15:   m = 20'd69906;
      5'd16:   m = 20'd65536;
      default: m = 20'hfffff;
    endcase
    return m;
  endfunction

endpackage

[hdl/fsad_ram.sv]
// generic single-clock ram, one write and one registered read port
`timescale 1ns / 1ps

module fsad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/fsad_accum.sv]
// accumulate stage: read-modify-write of the frame accumulator with forwarding
`timescale 1ns / 1ps

module fsad_accum
  import fsad_pkg::*;
#(
  parameter int AW    = 16,
  parameter int DEPTH = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  input  acc_req_t        req,
  input  logic [AW-1:0]   req_addr,
  output logic            busy,
  output div_req_t        div_req
);

  acc_req_t             s1_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 fwd_hit_r;
  logic [PIX_WIDTH-1:0] fwd_data_r;
  div_req_t             div_req_r;

  logic [PIX_WIDTH-1:0] rd_data;
  logic [PIX_WIDTH-1:0] quarter;
  logic [PIX_WIDTH-1:0] base;
  logic [PIX_WIDTH-1:0] sum;
  logic                 wr_en;
  logic [PIX_WIDTH-1:0] wr_data;
  div_req_t             div_req_nxt;

  fsad_ram #(
    .WIDTH (PIX_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_en   (req.valid),
    .rd_addr (req_addr),
    .rd_data (rd_data)
  );

  // stored value, taken from the write of the previous beat on a collision
  assign quarter = {2'b00, s1_r.pixel[PIX_WIDTH-1:2]};
  assign base    = fwd_hit_r ? fwd_data_r : rd_data;
  assign sum     = base + quarter;

  // write back and hand off emitting beats
  always_comb begin
    wr_en             = 1'b0;
    wr_data           = sum;
    div_req_nxt       = '0;
    div_req_nxt.last  = s1_r.last;
    div_req_nxt.comb  = s1_r.comb;
    div_req_nxt.value = sum;
    unique case (s1_r.op)
      ACC_FIRST: begin
        wr_en   = s1_r.valid;
        wr_data = quarter;
      end
      ACC_SUM: begin
        wr_en = s1_r.valid;
      end
      ACC_AVG: begin
        div_req_nxt.valid = s1_r.valid;
        div_req_nxt.avg   = 1'b1;
      end
      ACC_PASS: begin
        div_req_nxt.valid = s1_r.valid;
        div_req_nxt.value = s1_r.pixel & PASS_MASK;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // stage registers, only the valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid      <= 1'b0;
      div_req_r.valid <= 1'b0;
    end else begin
      s1_r.valid      <= req.valid;
      div_req_r.valid <= div_req_nxt.valid;
    end
    s1_r.op          <= req.op;
    s1_r.pixel       <= req.pixel;
    s1_r.last        <= req.last;
    s1_r.comb        <= req.comb;
    s1_addr_r        <= req_addr;
    fwd_hit_r        <= wr_en && (s1_addr_r == req_addr);
    fwd_data_r       <= wr_data;
    div_req_r.avg    <= div_req_nxt.avg;
    div_req_r.value  <= div_req_nxt.value;
    div_req_r.last   <= div_req_nxt.last;
    div_req_r.comb   <= div_req_nxt.comb;
  end

  assign busy    = s1_r.valid;
  assign div_req = div_req_r;

endmodule

[hdl/fsad_div.sv]
// divide stage: sum over combine count by reciprocal multiply, times four
`timescale 1ns / 1ps

module fsad_div
  import fsad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output res_t     res
);

  logic                  valid_r;
  logic                  avg_r;
  logic                  last_r;
  logic [PIX_WIDTH-1:0]  value_r;
  logic [PROD_WIDTH-1:0] prod_r;
  logic [PROD_WIDTH-1:0] prod_nxt;

  // quotient estimate, exact for 16-bit sums; a count of one passes the sum through
  assign prod_nxt = (req.comb == COUNT_WIDTH'(1)) ?
                    (PROD_WIDTH'(req.value) << RECIP_SHIFT) :
                    PROD_WIDTH'(req.value) * PROD_WIDTH'(recip(req.comb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    avg_r   <= req.avg;
    last_r  <= req.last;
    value_r <= req.value;
    prod_r  <= prod_nxt;
  end

  // quotient times four, wrapped to 16 bits, on average beats; other beats keep their value
  assign res.valid = valid_r;
  assign res.last  = last_r;
  assign res.value = avg_r ? {prod_r[RECIP_SHIFT+PIX_WIDTH-3:RECIP_SHIFT], 2'b00} : value_r;

endmodule

[hdl/fsad_outq.sv]
// output queue that decouples the pipeline from the result consumer
`timescale 1ns / 1ps

module fsad_outq
  import fsad_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  res_t                       push,
  output logic [$clog2(DEPTH):0]     count,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [PIX_WIDTH-1:0]       out_tdata,
  output logic                       out_tlast
);

  localparam int PW = $clog2(DEPTH);

  logic [PIX_WIDTH-1:0] data_mem [DEPTH];
  logic                 last_mem [DEPTH];
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        rd_ptr_r;
  logic [PW:0]          count_r;
  logic [PW:0]          count_nxt;
  logic                 pop;

  assign pop = out_tvalid && out_tready;

  // occupancy update
  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      data_mem[wr_ptr_r] <= push.value;
      last_mem[wr_ptr_r] <= push.last;
    end
  end

  assign count      = count_r;
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = data_mem[rd_ptr_r];
  assign out_tlast  = last_mem[rd_ptr_r];

endmodule

[hdl/frame_skip_average_decimator_core.sv]
// top level: frame counters, accumulator pipeline and output queue
`timescale 1ns / 1ps

// Frame decimator for a raster pixel stream. One input frame in skip_count is
// kept; kept frames are averaged combine_count at a time, pixel by pixel, in an
// accumulator ram of MAX_FRAME_PIXELS 16-bit words, and an output frame leaves
// only on the frame that completes a group (with combine_count 1 each kept
// pixel leaves masked to 14 bits). The block takes one pixel per clock while
// the output queue has room; the accumulator ram has one read and one write
// port. A result beat passes the accumulate and divide stages and the output
// queue. Skipped and non-final kept pixels produce no beat. The accumulator
// needs no clearing after reset: the first frame of every group overwrites
// it. Register writes take effect at once and should be made while idle.

module frame_skip_average_decimator_core
  import fsad_pkg::*;
#(
  parameter int MAX_FRAME_PIXELS = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  // input pixels
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] pixel_in
  // output pixels
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [15:0] pixel_out
  output logic                 out_tlast   // frame_last
);

  localparam int AW     = $clog2(MAX_FRAME_PIXELS);
  localparam int FW     = (AW + 1 > CFG_WIDTH) ? AW + 1 : CFG_WIDTH;
  localparam int QDEPTH = 8;
  localparam int QW     = $clog2(QDEPTH);

  logic [CFG_WIDTH-1:0]   frame_r;
  logic [COUNT_WIDTH-1:0] combine_r;
  logic [COUNT_WIDTH-1:0] skip_r;
  logic [AW-1:0]          pos_r;
  logic [3:0]             skip_phase_r;
  logic [3:0]             group_phase_r;

  logic [FW-1:0]          frame_wide;
  logic [AW:0]            fsize;
  logic [AW:0]            fsize_dec;
  logic [AW-1:0]          last_pos;
  logic [COUNT_WIDTH-1:0] comb_eff;
  logic [COUNT_WIDTH-1:0] skip_eff;
  logic                   last_pixel;
  logic [AW-1:0]          pos;
  logic                   kept;
  logic                   group_end;
  logic                   skip_end;
  logic                   accept;

  acc_req_t               acc_req;
  div_req_t               div_req;
  res_t                   res;
  logic                   acc_busy;
  logic [QW:0]            q_count;
  logic [QW:0]            in_flight;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= 17'h10000;
      combine_r <= 5'd1;
      skip_r    <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_PIXELS:  frame_r   <= cfg_data;
        CFG_COMBINE_COUNT: combine_r <= cfg_data[COUNT_WIDTH-1:0];
        CFG_SKIP_COUNT:    skip_r    <= cfg_data[COUNT_WIDTH-1:0];
        default:           frame_r   <= frame_r;
      endcase
    end
  end

  // effective frame size and counts
  always_comb begin
    frame_wide = FW'(frame_r);
    if (frame_wide == '0 || frame_wide > FW'(MAX_FRAME_PIXELS)) begin
      fsize = (AW+1)'(MAX_FRAME_PIXELS);
    end else begin
      fsize = frame_wide[AW:0];
    end
    fsize_dec = fsize - (AW+1)'(1);
    last_pos  = fsize_dec[AW-1:0];

    if (combine_r == '0) begin
      comb_eff = 5'd1;
    end else if (combine_r > 5'd16) begin
      comb_eff = 5'd16;
    end else begin
      comb_eff = combine_r;
    end
    if (skip_r == '0) begin
      skip_eff = 5'd1;
    end else if (skip_r > 5'd16) begin
      skip_eff = 5'd16;
    end else begin
      skip_eff = skip_r;
    end
  end

  // position and phase decode of the current pixel
  assign last_pixel = (pos_r >= last_pos);
  assign pos        = last_pixel ? last_pos : pos_r;
  assign kept       = (skip_phase_r == '0);
  assign group_end  = ({1'b0, group_phase_r} >= comb_eff - 5'd1);
  assign skip_end   = ({1'b0, skip_phase_r} >= skip_eff - 5'd1);

  // room in the queue for every beat that may still be on its way
  assign in_flight = (QW+1)'(acc_busy) + (QW+1)'(div_req.valid) + (QW+1)'(res.valid);
  assign in_tready = (q_count + in_flight) < (QW+1)'(QDEPTH);
  assign accept    = in_tvalid && in_tready;

  // frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      skip_phase_r  <= '0;
      group_phase_r <= '0;
    end else if (accept) begin
      if (last_pixel) begin
        pos_r <= '0;
        if (kept) begin
          group_phase_r <= group_end ? 4'd0 : group_phase_r + 4'd1;
        end
        skip_phase_r <= skip_end ? 4'd0 : skip_phase_r + 4'd1;
      end else begin
        pos_r <= pos + 1'b1;
      end
    end
  end

  // request to the accumulate stage
  always_comb begin
    acc_req.valid = accept && kept;
    acc_req.pixel = in_tdata;
    acc_req.last  = last_pixel;
    acc_req.comb  = comb_eff;
    priority if (group_phase_r == '0) begin
      acc_req.op = group_end ? ACC_PASS : ACC_FIRST;
    end else begin
      acc_req.op = group_end ? ACC_AVG : ACC_SUM;
    end
  end

  fsad_accum #(
    .AW    (AW),
    .DEPTH (MAX_FRAME_PIXELS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (acc_req),
    .req_addr (pos),
    .busy     (acc_busy),
    .div_req  (div_req)
  );

  fsad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (res)
  );

  fsad_outq #(
    .DEPTH (QDEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res),
    .count      (q_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
